/* design/c80alu_pkg.sv */
// ----------------------------------------------------------------------------
// c80alu_pkg
// Shared types, operation codes and flag helpers for the 8080-style ALU.
// ----------------------------------------------------------------------------
package c80alu_pkg;

    // Operation codes; codes 17 to 31 are no-ops
    typedef enum logic [4:0] {
        CMD_ADD = 5'd0,
        CMD_ADC = 5'd1,
        CMD_SUB = 5'd2,
        CMD_SBB = 5'd3,
        CMD_ANA = 5'd4,
        CMD_XRA = 5'd5,
        CMD_ORA = 5'd6,
        CMD_CMP = 5'd7,
        CMD_INR = 5'd8,
        CMD_DCR = 5'd9,
        CMD_RLC = 5'd10,
        CMD_RRC = 5'd11,
        CMD_RAL = 5'd12,
        CMD_RAR = 5'd13,
        CMD_CMA = 5'd14,
        CMD_STC = 5'd15,
        CMD_CMC = 5'd16
    } cmd_t;

    // Flag bit positions
    localparam int FLAG_S  = 4;
    localparam int FLAG_Z  = 3;
    localparam int FLAG_AC = 2;
    localparam int FLAG_P  = 1;
    localparam int FLAG_CY = 0;

    typedef struct packed {
        logic [4:0] command;
        logic [7:0] accumulator;
        logic [7:0] operand;
        logic [4:0] flags_in;
    } req_t;

    typedef struct packed {
        logic [7:0] result;
        logic [4:0] flags_out;
        logic       write_result;
    } rsp_t;

    // Sign, zero and parity of a byte; aux carry and carry left clear
    function automatic logic [4:0] szp_of(input logic [7:0] v);
        logic [4:0] f;
        f          = 5'b00000;
        f[FLAG_S]  = v[7];
        f[FLAG_Z]  = (v == 8'h00);
        f[FLAG_P]  = ~^v;
        return f;
    endfunction

endpackage

/* design/cpu8080_alu_with_flags.sv */
// ----------------------------------------------------------------------------
// cpu8080_alu_with_flags
// 8080-style accumulator ALU with flag update, one transaction per cycle.
// ----------------------------------------------------------------------------
// A transaction is taken at every rising edge where start is high; busy is
// always low, so a new transaction may follow in every cycle. The request is
// captured in an input register, passes the ALU and flag logic, and lands in
// a result register: each result appears on response with done high for a
// single cycle. The receiver has no way to stall, so it must take response
// in the cycle that done marks. Throughput is one transaction per clock.
// ----------------------------------------------------------------------------
module cpu8080_alu_with_flags (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  c80alu_pkg::req_t request,
    output logic             done,
    output c80alu_pkg::rsp_t response
);
    import c80alu_pkg::*;

    logic valid_in_reg;
    logic valid_in_next;
    logic valid_out_reg;
    logic valid_out_next;
    req_t req_reg;
    req_t req_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // Never stall the sender: the datapath takes a transaction every cycle
    assign busy = 1'b0;

    // Capture a new transaction whenever start is seen; otherwise hold
    assign valid_in_next  = start & ~busy;
    assign req_next       = valid_in_next ? request : req_reg;
    assign valid_out_next = valid_in_reg;

    c80alu_core u_core (
        .request  (req_reg),
        .response (rsp_next)
    );

    // Control: valid bits advance one stage per clock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in_reg  <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid_in_reg  <= valid_in_next;
            valid_out_reg <= valid_out_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        if (valid_in_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done     = valid_out_reg;
    assign response = rsp_reg;

    // Every accepted transaction yields its result through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("accepted transaction did not complete in two cycles");

    // Nothing completes that was not accepted through the input register
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result strobe without an accepted transaction");

    // Compare never writes back and leaves the accumulator result path alone
    a_cmp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(request.command, 2) == CMD_CMP) |-> !response.write_result)
        else $error("compare marked its result for write-back");

    // Complement keeps all flags as they came in
    a_cma_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(request.command, 2) == CMD_CMA)
            |-> response.flags_out == $past(request.flags_in, 2))
        else $error("complement changed the flags");

endmodule

/* design/c80alu_core.sv */
// ----------------------------------------------------------------------------
// c80alu_core
// Combinational datapath: shared 8-bit adder, logic ops, rotates and flags.
// ----------------------------------------------------------------------------
module c80alu_core (
    input  c80alu_pkg::req_t request,
    output c80alu_pkg::rsp_t response
);
    import c80alu_pkg::*;

    logic [7:0] add_a;
    logic [7:0] add_b;
    logic       add_cin;
    logic [8:0] sum;
    logic [4:0] low_sum;
    logic       cy;
    logic [7:0] acc;
    logic [4:0] fin;

    assign cy  = request.flags_in[FLAG_CY];
    assign acc = request.accumulator;
    assign fin = request.flags_in;

    // Select adder operands; subtraction adds the inverted operand
    always_comb
    begin
        add_a   = acc;
        add_b   = request.operand;
        add_cin = 1'b0;
        case (request.command)
            CMD_ADC:
            begin
                add_cin = cy;
            end
            CMD_SUB, CMD_CMP:
            begin
                add_b   = ~request.operand;
                add_cin = 1'b1;
            end
            CMD_SBB:
            begin
                add_b   = ~request.operand;
                add_cin = ~cy;
            end
            CMD_INR:
            begin
                add_a = request.operand;
                add_b = 8'h01;
            end
            CMD_DCR:
            begin
                add_a = request.operand;
                add_b = 8'hFF;
            end
            default:
            begin
                add_a = acc;
            end
        endcase
    end

    assign sum     = {1'b0, add_a} + {1'b0, add_b} + {8'b0, add_cin};
    assign low_sum = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]} + {4'b0, add_cin};

    always_comb
    begin
        response.result       = acc;
        response.flags_out    = fin;
        response.write_result = 1'b1;
        case (request.command)
            CMD_ADD, CMD_ADC:
            begin
                response.result                = sum[7:0];
                response.flags_out             = szp_of(sum[7:0]);
                response.flags_out[FLAG_AC]    = low_sum[4];
                response.flags_out[FLAG_CY]    = sum[8];
            end
            CMD_SUB, CMD_SBB, CMD_CMP:
            begin
                response.result                = sum[7:0];
                response.flags_out             = szp_of(sum[7:0]);
                response.flags_out[FLAG_AC]    = low_sum[4];
                response.flags_out[FLAG_CY]    = ~sum[8];
                response.write_result          = (request.command != CMD_CMP);
            end
            CMD_ANA:
            begin
                response.result                = acc & request.operand;
                response.flags_out             = szp_of(acc & request.operand);
                response.flags_out[FLAG_AC]    = fin[FLAG_AC];
            end
            CMD_XRA:
            begin
                response.result                = acc ^ request.operand;
                response.flags_out             = szp_of(acc ^ request.operand);
            end
            CMD_ORA:
            begin
                response.result                = acc | request.operand;
                response.flags_out             = szp_of(acc | request.operand);
                response.flags_out[FLAG_AC]    = fin[FLAG_AC];
            end
            CMD_INR, CMD_DCR:
            begin
                response.result                = sum[7:0];
                response.flags_out             = szp_of(sum[7:0]);
                response.flags_out[FLAG_AC]    = low_sum[4];
                response.flags_out[FLAG_CY]    = cy;
            end
            CMD_RLC:
            begin
                response.result                = {acc[6:0], acc[7]};
                response.flags_out[FLAG_CY]    = acc[7];
            end
            CMD_RRC:
            begin
                response.result                = {acc[0], acc[7:1]};
                response.flags_out[FLAG_CY]    = acc[0];
            end
            CMD_RAL:
            begin
                response.result                = {acc[6:0], cy};
                response.flags_out[FLAG_CY]    = acc[7];
            end
            CMD_RAR:
            begin
                response.result                = {cy, acc[7:1]};
                response.flags_out[FLAG_CY]    = acc[0];
            end
            CMD_CMA:
            begin
                response.result                = ~acc;
            end
            CMD_STC:
            begin
                response.flags_out[FLAG_CY]    = 1'b1;
                response.write_result          = 1'b0;
            end
            CMD_CMC:
            begin
                response.flags_out[FLAG_CY]    = ~cy;
                response.write_result          = 1'b0;
            end
            default:
            begin
                response.write_result          = 1'b0;
            end
        endcase
    end

endmodule
